// File: design/mtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtt_pkg;

    // Table size and derived widths
    localparam int NUM_TIMERS = 16;
    localparam int ADDR_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MAX_OUT    = 16;
    localparam int FIRE_CNT_W = $clog2(MAX_OUT + 1);

    // Request opcodes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_INIT    = 3'd1;
    localparam logic [2:0] OP_START   = 3'd2;
    localparam logic [2:0] OP_STOP    = 3'd3;
    localparam logic [2:0] OP_DESTROY = 3'd4;
    localparam logic [2:0] OP_QUERY   = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_FIRED = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_IDLE  = 2'd2;
    localparam logic [1:0] KIND_ACK   = 2'd3;

    // Lifecycle codes
    localparam logic [2:0] LC_NONE      = 3'd0;
    localparam logic [2:0] LC_CREATED   = 3'd1;
    localparam logic [2:0] LC_STARTED   = 3'd2;
    localparam logic [2:0] LC_STOPPED   = 3'd3;
    localparam logic [2:0] LC_DESTROYED = 3'd4;

    // One table entry as stored in the memory
    typedef struct packed {
        logic [31:0] delay;
        logic [31:0] period;
        logic [31:0] count;
        logic        hard;
        logic [2:0]  life;
    } entry_t;

    // Outcome of one entry's tick update
    typedef struct packed {
        logic   active;
        logic   fire;
        entry_t ent;
    } tick_res_t;

endpackage

`default_nettype wire

// File: design/multi_channel_tick_timer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Control and query requests: the ST_OP state loads the result into the output register
// once that register is free, then returns to idle, where the next request is taken.
// Tick requests: each entry takes a read state, then an update and write-back state,
// in each of two passes (hard, soft); after the soft pass, ST_WALK_END registers the
// last result once the output register is free. A reportable fire that must push out a
// held one while the output register is still full holds the walk.
// One request in flight; the next is accepted once the last result is registered.
// Reset (aresetn low, synchronous) clears the state machine, output valid and all entry valid bits.
module multi_channel_tick_timer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [3:0]  s_timer_index,
    input  wire logic [31:0] s_start_delay,
    input  wire logic [31:0] s_period,
    input  wire logic        s_hard,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [3:0]       m_out_index,
    output logic [2:0]       m_timer_status,
    output logic [31:0]      m_out_start_delay,
    output logic [31:0]      m_out_period,
    output logic             m_out_hard,
    output logic             m_last
);

    localparam int AW = mtt_pkg::ADDR_W;
    localparam int CW = mtt_pkg::FIRE_CNT_W;
    localparam logic [8:0]    NUM_V   = 9'(mtt_pkg::NUM_TIMERS);
    localparam logic [AW-1:0] LAST_AD = AW'(mtt_pkg::NUM_TIMERS - 1);
    localparam logic [CW-1:0] MAX_V   = CW'(mtt_pkg::MAX_OUT);

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_OP        = 5'b00010,
        ST_WALK_RD   = 5'b00100,
        ST_WALK_PROC = 5'b01000,
        ST_WALK_END  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Latched request
    logic [2:0]  op_reg, op_next;
    logic [3:0]  idx_reg, idx_next;
    logic [31:0] dly_reg, dly_next;
    logic [31:0] per_reg, per_next;
    logic        hrd_reg, hrd_next;

    // Walk control
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          grp_reg, grp_next;       // 1: hard pass, 0: soft pass
    logic [CW-1:0] fcnt_reg, fcnt_next;

    // Held fire event; its last flag is known only when the next one shows up
    logic          pend_vld_reg, pend_vld_next;
    logic [3:0]    pend_idx_reg, pend_idx_next;
    logic [2:0]    pend_st_reg, pend_st_next;

    // Entry memory, registered read
    mtt_pkg::entry_t mem [mtt_pkg::NUM_TIMERS];
    mtt_pkg::entry_t rdata_reg;
    logic            rvalid_reg;
    logic [mtt_pkg::NUM_TIMERS-1:0] ent_vld_reg;

    logic            mem_re, mem_we;
    logic [AW-1:0]   mem_raddr, mem_waddr;
    mtt_pkg::entry_t mem_wdata;

    // Output register
    logic        m_valid_reg;
    logic        out_load;
    logic [1:0]  o_kind;
    logic [3:0]  o_idx;
    logic [2:0]  o_st;
    logic [31:0] o_dly, o_per;
    logic        o_hrd, o_last;
    logic [1:0]  kind_reg;
    logic [3:0]  oidx_reg;
    logic [2:0]  ost_reg;
    logic [31:0] odly_reg, oper_reg;
    logic        ohrd_reg, olast_reg;

    logic               out_free;
    logic               idx_ok;
    logic               accept;
    mtt_pkg::entry_t    cur;
    mtt_pkg::entry_t    upd;
    mtt_pkg::tick_res_t tick_res;
    logic [31:0]        reload;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign idx_ok   = ({5'd0, idx_reg} < NUM_V);

    // An entry never written reads as all zero (never initialized)
    assign cur    = rvalid_reg ? rdata_reg : '0;
    assign reload = (cur.delay != 32'd0) ? cur.delay : cur.period;

    mtt_tick_step u_tick_step (
        .ent_i       (cur),
        .want_hard_i (grp_reg),
        .res_o       (tick_res)
    );

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        dly_next      = dly_reg;
        per_next      = per_reg;
        hrd_next      = hrd_reg;
        ptr_next      = ptr_reg;
        grp_next      = grp_reg;
        fcnt_next     = fcnt_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        pend_st_next  = pend_st_reg;

        mem_re    = 1'b0;
        mem_raddr = ptr_reg;
        mem_we    = 1'b0;
        mem_waddr = AW'(idx_reg);
        mem_wdata = cur;
        upd       = cur;

        out_load = 1'b0;
        o_kind   = mtt_pkg::KIND_ACK;
        o_idx    = idx_reg;
        o_st     = mtt_pkg::LC_NONE;
        o_dly    = 32'd0;
        o_per    = 32'd0;
        o_hrd    = 1'b0;
        o_last   = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next  = s_op;
                    idx_next = s_timer_index;
                    dly_next = s_start_delay;
                    per_next = s_period;
                    hrd_next = s_hard;
                    // Issue the entry read alongside the accept
                    mem_re    = 1'b1;
                    mem_raddr = AW'(s_timer_index);
                    case (s_op)
                        mtt_pkg::OP_TICK: begin
                            ptr_next      = '0;
                            grp_next      = 1'b1;
                            fcnt_next     = '0;
                            pend_vld_next = 1'b0;
                            mem_re        = 1'b0;
                            state_next    = ST_WALK_RD;
                        end
                        mtt_pkg::OP_INIT, mtt_pkg::OP_START, mtt_pkg::OP_STOP,
                        mtt_pkg::OP_DESTROY, mtt_pkg::OP_QUERY: begin
                            state_next = ST_OP;
                        end
                        default: begin
                            // Unknown opcode: drop silently
                            mem_re = 1'b0;
                        end
                    endcase
                end
            end

            ST_OP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    o_kind = (op_reg == mtt_pkg::OP_QUERY) ? mtt_pkg::KIND_QUERY
                                                           : mtt_pkg::KIND_ACK;
                    if (idx_ok) begin
                        unique case (op_reg)
                            mtt_pkg::OP_INIT: begin
                                upd.delay  = dly_reg;
                                upd.period = per_reg;
                                upd.hard   = hrd_reg;
                                upd.count  = (dly_reg != 32'd0) ? dly_reg : per_reg;
                                upd.life   = mtt_pkg::LC_CREATED;
                            end
                            mtt_pkg::OP_START: begin
                                if (cur.life == mtt_pkg::LC_CREATED ||
                                    cur.life == mtt_pkg::LC_STOPPED) begin
                                    upd.count = reload;
                                    upd.life  = mtt_pkg::LC_STARTED;
                                end
                            end
                            mtt_pkg::OP_STOP: begin
                                if (cur.life == mtt_pkg::LC_STARTED) begin
                                    upd.life = mtt_pkg::LC_STOPPED;
                                end
                            end
                            mtt_pkg::OP_DESTROY: begin
                                upd.life = mtt_pkg::LC_DESTROYED;
                            end
                            default: begin
                                // Query: report stored settings
                                o_dly = cur.delay;
                                o_per = cur.period;
                                o_hrd = cur.hard;
                            end
                        endcase
                        mem_we    = (op_reg != mtt_pkg::OP_QUERY);
                        mem_wdata = upd;
                        o_st      = upd.life;
                    end
                end
            end

            ST_WALK_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = ptr_reg;
                state_next = ST_WALK_PROC;
            end

            ST_WALK_PROC: begin
                // Hold while a second reportable fire needs the busy output slot
                if (!(tick_res.active && tick_res.fire && fcnt_reg < MAX_V &&
                      pend_vld_reg && !out_free)) begin
                    if (tick_res.active) begin
                        mem_we    = 1'b1;
                        mem_waddr = ptr_reg;
                        mem_wdata = tick_res.ent;
                        if (tick_res.fire && fcnt_reg < MAX_V) begin
                            if (pend_vld_reg) begin
                                out_load = 1'b1;
                                o_kind   = mtt_pkg::KIND_FIRED;
                                o_idx    = pend_idx_reg;
                                o_st     = pend_st_reg;
                                o_last   = 1'b0;
                            end
                            pend_vld_next = 1'b1;
                            pend_idx_next = 4'(ptr_reg);
                            pend_st_next  = tick_res.ent.life;
                            fcnt_next     = fcnt_reg + CW'(1);
                        end
                    end
                    if (ptr_reg == LAST_AD) begin
                        ptr_next = '0;
                        if (grp_reg) begin
                            grp_next   = 1'b0;
                            state_next = ST_WALK_RD;
                        end else begin
                            state_next = ST_WALK_END;
                        end
                    end else begin
                        ptr_next   = ptr_reg + AW'(1);
                        state_next = ST_WALK_RD;
                    end
                end
            end

            ST_WALK_END: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (pend_vld_reg) begin
                        o_kind = mtt_pkg::KIND_FIRED;
                        o_idx  = pend_idx_reg;
                        o_st   = pend_st_reg;
                    end else begin
                        o_kind = mtt_pkg::KIND_IDLE;
                        o_idx  = 4'd0;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_vld_reg <= 1'b0;
            fcnt_reg     <= '0;
            grp_reg      <= 1'b0;
            ptr_reg      <= '0;
            m_valid_reg  <= 1'b0;
            ent_vld_reg  <= '0;
            rvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            fcnt_reg     <= fcnt_next;
            grp_reg      <= grp_next;
            ptr_reg      <= ptr_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (mem_we) begin
                ent_vld_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re) begin
                rvalid_reg <= ent_vld_reg[mem_raddr];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        dly_reg      <= dly_next;
        per_reg      <= per_next;
        hrd_reg      <= hrd_next;
        pend_idx_reg <= pend_idx_next;
        pend_st_reg  <= pend_st_next;
        if (out_load) begin
            kind_reg  <= o_kind;
            oidx_reg  <= o_idx;
            ost_reg   <= o_st;
            odly_reg  <= o_dly;
            oper_reg  <= o_per;
            ohrd_reg  <= o_hrd;
            olast_reg <= o_last;
        end
    end

    // Entry memory: reads and writes never target the same cycle, the sequencer
    // always separates the read of an entry from its write-back
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_kind            = kind_reg;
    assign m_out_index       = oidx_reg;
    assign m_timer_status    = ost_reg;
    assign m_out_start_delay = odly_reg;
    assign m_out_period      = oper_reg;
    assign m_out_hard        = ohrd_reg;
    assign m_last            = olast_reg;

endmodule

`default_nettype wire

// File: design/mtt_tick_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Tick update of one entry: decrement, detect expiry, reload or stop.
module mtt_tick_step (
    input  mtt_pkg::entry_t    ent_i,
    input  logic               want_hard_i,
    output mtt_pkg::tick_res_t res_o
);

    logic        is_zero;
    logic [31:0] count_dec;

    assign is_zero   = (ent_i.count == 32'd0);
    assign count_dec = ent_i.count - 32'd1;

    always_comb begin
        res_o.active = (ent_i.life == mtt_pkg::LC_STARTED) && (ent_i.hard == want_hard_i);
        res_o.fire   = is_zero || (count_dec == 32'd0);
        res_o.ent    = ent_i;
        if (!is_zero) begin
            res_o.ent.count = count_dec;
        end
        if (res_o.fire) begin
            if (ent_i.period != 32'd0) begin
                res_o.ent.count = ent_i.period;
            end else begin
                res_o.ent.life = mtt_pkg::LC_STOPPED;
            end
        end
    end

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // Op codes the block must ignore without a result
    localparam logic [2:0] OP_RESERVED_6 = 3'd6;
    localparam logic [2:0] OP_RESERVED_7 = 3'd7;

    // Cycles with no handshake on either side before the run is declared hung.
    // The worst legal gap is the long receiver hold-off (HOLD_OFF_CYCLES) plus a
    // full tick walk, so this leaves a wide margin.
    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    // A tick walks every entry twice, with a read and an update step per entry.
    localparam int SETTLE_CYCLES   = 4 * mtt_pkg::NUM_TIMERS + 16;

    // One result as it appears on the m_ channel
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  index;
        logic [2:0]  status;
        logic [31:0] start_delay;
        logic [31:0] period;
        logic        hard;
        logic        last;
    } timer_result_t;

    logic        aclk;
    logic        aresetn           = 1'b0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op              = mtt_pkg::OP_TICK;
    logic [3:0]  s_timer_index     = '0;
    logic [31:0] s_start_delay     = '0;
    logic [31:0] s_period          = '0;
    logic        s_hard            = 1'b0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic [1:0]  m_kind;
    logic [3:0]  m_out_index;
    logic [2:0]  m_timer_status;
    logic [31:0] m_out_start_delay;
    logic [31:0] m_out_period;
    logic        m_out_hard;
    logic        m_last;

    // Expected copy of the timer table
    logic [31:0] tmr_delay  [mtt_pkg::NUM_TIMERS];
    logic [31:0] tmr_period [mtt_pkg::NUM_TIMERS];
    logic [31:0] tmr_count  [mtt_pkg::NUM_TIMERS];
    logic        tmr_hard   [mtt_pkg::NUM_TIMERS];
    logic [2:0]  tmr_life   [mtt_pkg::NUM_TIMERS];

    timer_result_t pending_results[$];

    int error_count    = 0;
    int quiet_cycles   = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;

    multi_channel_tick_timer_unit uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_timer_index     (s_timer_index),
        .s_start_delay     (s_start_delay),
        .s_period          (s_period),
        .s_hard            (s_hard),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_out_index       (m_out_index),
        .m_timer_status    (m_timer_status),
        .m_out_start_delay (m_out_start_delay),
        .m_out_period      (m_out_period),
        .m_out_hard        (m_out_hard),
        .m_last            (m_last)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Apply one accepted request to the expected table and queue the results it
    // should produce, in the order the block must emit them.
    task automatic predict_request(input logic [2:0] op, input logic [3:0] idx,
                                   input logic [31:0] dly, input logic [31:0] per,
                                   input logic hrd);
        timer_result_t burst [mtt_pkg::MAX_OUT];
        timer_result_t r;
        int            n;
        logic          fire;
        n = 0;
        r = '0;
        if (op == mtt_pkg::OP_TICK) begin
            // Walk the hard group on the first pass, the soft group on the second
            for (int g = 0; g < 2; g++) begin
                for (int i = 0; i < mtt_pkg::NUM_TIMERS; i++) begin
                    if (tmr_life[i] != mtt_pkg::LC_STARTED || tmr_hard[i] != (g == 0))
                        continue;
                    if (tmr_count[i] == 0) begin
                        fire = 1'b1;
                    end else begin
                        tmr_count[i] = tmr_count[i] - 32'd1;
                        fire = (tmr_count[i] == 32'd0);
                    end
                    if (!fire)
                        continue;
                    // Reload a periodic timer, stop a one-shot
                    if (tmr_period[i] != 0)
                        tmr_count[i] = tmr_period[i];
                    else
                        tmr_life[i] = mtt_pkg::LC_STOPPED;
                    if (n < mtt_pkg::MAX_OUT) begin
                        r        = '0;
                        r.kind   = mtt_pkg::KIND_FIRED;
                        r.index  = i[3:0];
                        r.status = tmr_life[i];
                        burst[n] = r;
                        n++;
                    end
                end
            end
            if (n == 0) begin
                r      = '0;
                r.kind = mtt_pkg::KIND_IDLE;
                r.last = 1'b1;
                pending_results.push_back(r);
            end
            for (int k = 0; k < n; k++) begin
                r      = burst[k];
                r.last = (k == n - 1);
                pending_results.push_back(r);
            end
        end else if (op <= mtt_pkg::OP_QUERY) begin
            r.index = idx;
            r.last  = 1'b1;
            r.kind  = (op == mtt_pkg::OP_QUERY) ? mtt_pkg::KIND_QUERY : mtt_pkg::KIND_ACK;
            // Out-of-table index: answer with status zero and change nothing
            if (idx < mtt_pkg::NUM_TIMERS) begin
                case (op)
                    mtt_pkg::OP_INIT: begin
                        tmr_delay[idx]  = dly;
                        tmr_period[idx] = per;
                        tmr_hard[idx]   = hrd;
                        tmr_count[idx]  = (dly != 0) ? dly : per;
                        tmr_life[idx]   = mtt_pkg::LC_CREATED;
                    end
                    mtt_pkg::OP_START: begin
                        if (tmr_life[idx] == mtt_pkg::LC_CREATED ||
                            tmr_life[idx] == mtt_pkg::LC_STOPPED) begin
                            tmr_count[idx] = (tmr_delay[idx] != 0) ? tmr_delay[idx]
                                                                   : tmr_period[idx];
                            tmr_life[idx]  = mtt_pkg::LC_STARTED;
                        end
                    end
                    mtt_pkg::OP_STOP: begin
                        if (tmr_life[idx] == mtt_pkg::LC_STARTED)
                            tmr_life[idx] = mtt_pkg::LC_STOPPED;
                    end
                    mtt_pkg::OP_DESTROY: begin
                        tmr_life[idx] = mtt_pkg::LC_DESTROYED;
                    end
                    default: begin
                        r.start_delay = tmr_delay[idx];
                        r.period      = tmr_period[idx];
                        r.hard        = tmr_hard[idx];
                    end
                endcase
                r.status = tmr_life[idx];
            end
            pending_results.push_back(r);
        end
        // Reserved op codes: no state change and no result
    endtask

    // Offer one request, idling first at the current sender rate. Valid stays
    // high after acceptance; the next request or drain_results takes it over.
    task automatic send_request(input logic [2:0] op, input logic [3:0] idx,
                                input logic [31:0] dly, input logic [31:0] per,
                                input logic hrd);
        @(negedge aclk);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_op          <= op;
        s_timer_index <= idx;
        s_start_delay <= dly;
        s_period      <= per;
        s_hard        <= hrd;
        s_valid       <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_request(op, idx, dly, per, hrd);
    endtask

    // Drop valid, wait for every expected result, then let the block settle
    task automatic drain_results;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Random request: mostly small delays so timers actually fire, with a share
    // of full-width values and ignored op codes as noise. counted is low for
    // requests the block ignores.
    task automatic send_random_request(output bit counted);
        logic [2:0]  op;
        logic [3:0]  idx;
        logic [31:0] dly;
        logic [31:0] per;
        logic        hrd;
        int          pick;
        pick = int'($urandom_range(99));
        idx  = 4'($urandom_range(15));
        hrd  = 1'($urandom_range(1));
        if ($urandom_range(9) == 0) begin
            dly = $urandom;
            per = $urandom;
        end else begin
            dly = $urandom_range(4);
            per = $urandom_range(3);
        end
        if (pick < 35)
            op = mtt_pkg::OP_TICK;
        else if (pick < 50)
            op = mtt_pkg::OP_INIT;
        else if (pick < 70)
            op = mtt_pkg::OP_START;
        else if (pick < 78)
            op = mtt_pkg::OP_STOP;
        else if (pick < 83)
            op = mtt_pkg::OP_DESTROY;
        else if (pick < 95)
            op = mtt_pkg::OP_QUERY;
        else
            op = ($urandom_range(1) != 0) ? OP_RESERVED_6 : OP_RESERVED_7;
        counted = (op <= mtt_pkg::OP_QUERY);
        send_request(op, idx, dly, per, hrd);
    endtask

    // Query untouched entries at both ends of the table, then poke one with
    // start and stop, which must leave it uninitialized.
    task automatic test_power_up_query;
        send_request(mtt_pkg::OP_QUERY, 4'd0, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_QUERY, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(mtt_pkg::OP_START, 4'd15, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_STOP, 4'd15, 32'h0, 32'h0, 1'b0);
        drain_results();
    endtask

    // Walk one timer through lifecycle transitions, legal and not, with
    // the widest delay and period; finish with the reserved op codes.
    task automatic test_lifecycle_controls;
        send_request(mtt_pkg::OP_INIT, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(mtt_pkg::OP_QUERY, 4'd3, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_STOP, 4'd3, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_START, 4'd3, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_START, 4'd3, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_STOP, 4'd3, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_START, 4'd3, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_DESTROY, 4'd3, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_START, 4'd3, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_QUERY, 4'd3, 32'h0, 32'h0, 1'b0);
        send_request(OP_RESERVED_6, 4'd3, 32'h1, 32'h1, 1'b1);
        send_request(OP_RESERVED_7, 4'd0, 32'h0, 32'h0, 1'b0);
        drain_results();
    endtask

    // Fire soft timers 0 and 9 and hard timer 2 on one tick: the hard one must
    // come first. Timer 0 has zero delay and period, so it fires at once and
    // stops. The second tick fires nothing, the third reloads timer 2 again.
    task automatic test_tick_ordering;
        send_request(mtt_pkg::OP_INIT, 4'd0, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_START, 4'd0, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_INIT, 4'd9, 32'h1, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_START, 4'd9, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_INIT, 4'd2, 32'h1, 32'h2, 1'b1);
        send_request(mtt_pkg::OP_START, 4'd2, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_TICK, 4'd0, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_TICK, 4'd0, 32'h0, 32'h0, 1'b0);
        send_request(mtt_pkg::OP_TICK, 4'd0, 32'h0, 32'h0, 1'b0);
        drain_results();
    endtask

    task automatic test_random_traffic(input int requests, input int idle_pct,
                                       input int stall_pct);
        int served;
        bit counted;
        served         = 0;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        while (served < requests) begin
            send_random_request(counted);
            if (counted)
                served++;
        end
        drain_results();
    endtask

    // Hold the result side off for a long stretch while requests keep coming,
    // so the block backs up and drops s_ready.
    task automatic test_backpressure_fill;
        bit counted;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = HOLD_OFF_CYCLES;
        repeat (12) send_random_request(counted);
        drain_results();
    endtask

    // Result side: hold off when asked, otherwise stall at the current rate
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Compare every accepted result with the oldest expected one
    always @(posedge aclk) begin
        timer_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: kind %0h index %0h status %0h",
                         $time, m_kind, m_out_index, m_timer_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_kind));
                check_field("out_index", 32'(want.index), 32'(m_out_index));
                check_field("timer_status", 32'(want.status), 32'(m_timer_status));
                check_field("out_start_delay", want.start_delay, m_out_start_delay);
                check_field("out_period", want.period, m_out_period);
                check_field("out_hard", 32'(want.hard), 32'(m_out_hard));
                check_field("last", 32'(want.last), 32'(m_last));
            end
        end
    end

    // Hang guard: count cycles with no handshake on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("multi_channel_tick_timer_unit verification failed");
            $finish;
        end
    end

    initial begin
        // Expected table matches the block's cleared state
        for (int i = 0; i < mtt_pkg::NUM_TIMERS; i++) begin
            tmr_delay[i]  = '0;
            tmr_period[i] = '0;
            tmr_count[i]  = '0;
            tmr_hard[i]   = 1'b0;
            tmr_life[i]   = mtt_pkg::LC_NONE;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_power_up_query();
        test_lifecycle_controls();
        test_tick_ordering();
        test_random_traffic(65, 0, 0);
        test_random_traffic(65, 81, 0);
        test_random_traffic(65, 0, 81);
        test_random_traffic(65, 13, 13);
        test_backpressure_fill();

        if (error_count == 0)
            $display("multi_channel_tick_timer_unit verification clean");
        else
            $display("multi_channel_tick_timer_unit verification failed");
        $finish;
    end

endmodule

// File: multi_channel_tick_timer_unit.f
design/mtt_pkg.sv
design/mtt_tick_step.sv
design/multi_channel_tick_timer_unit.sv
bench/testbench.sv
